// File: rtl/core/bounded_ordered_list_engine_top_defines.svh
// Assertion macros for the ordered list engine.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_TOP_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define BOLE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bole assertion failed");
// Condition that must never be true outside reset.
`define BOLE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bole forbidden condition seen");
`else
`define BOLE_ASSERT(lbl, clk, rst_n, prop)
`define BOLE_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: rtl/core/bole_pkg.sv
// Shared constants, codes and types of the ordered list engine.
`default_nettype none

package bole_pkg;

  localparam int DEPTH  = 16;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = 5;
  localparam int VAL_W  = 32;
  localparam int TYPE_W = 3;
  localparam int STAT_W = 2;

  localparam logic [TYPE_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_INSERT_AT  = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_POP_BACK   = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_REMOVE_AT  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [VAL_W-1:0]  value;
    logic [4:0]        position;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  removed_value;
    logic [CNT_W-1:0]  count;
  } rsp_t;

  // Access to the value and link memories; both share the addresses.
  typedef struct packed {
    logic              we_val;
    logic              we_link;
    logic [SLOT_W-1:0] waddr;
    logic [VAL_W-1:0]  wval;
    logic [SLOT_W-1:0] wlink;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
  } ctl_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/bole_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bole_ram #(
  parameter int WIDTH = 32,
  parameter int WORDS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(WORDS)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(WORDS)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [WORDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/bole_ctrl.sv
// Request sequencer: list pointers, free map, link walk and memory updates.
`default_nettype none

module bole_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      req_valid_i,
  input  wire bole_pkg::req_t            req_i,
  input  wire logic                      res_ready_i,
  output bole_pkg::ctl_sts_t             sts_o,
  output bole_pkg::rsp_t                 rsp_o,
  output bole_pkg::mem_req_t             mem_o,
  input  wire logic [bole_pkg::VAL_W-1:0]  val_rdata_i,
  input  wire logic [bole_pkg::SLOT_W-1:0] link_rdata_i
);
  import bole_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_NEXT = 3'd2;
  localparam logic [2:0] S_CUR  = 3'd3;
  localparam logic [2:0] S_WR1  = 3'd4;
  localparam logic [2:0] S_WR2  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [2:0] OP_NONE       = 3'd0;
  localparam logic [2:0] OP_INS_FRONT  = 3'd1;
  localparam logic [2:0] OP_INS_BACK   = 3'd2;
  localparam logic [2:0] OP_INS_MID    = 3'd3;
  localparam logic [2:0] OP_POP_FRONT  = 3'd4;
  localparam logic [2:0] OP_DROP_AFTER = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [2:0]        op_q, op_d;
  logic [SLOT_W-1:0] head_q, head_d;
  logic [SLOT_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [DEPTH-1:0]  free_q, free_d;
  logic [CNT_W-1:0]  hops_q, hops_d;
  logic              rdv_q, rdv_d;

  logic [VAL_W-1:0]  val_q, val_d;
  logic [VAL_W-1:0]  removed_q, removed_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [SLOT_W-1:0] cur_q, cur_d;
  logic [SLOT_W-1:0] prev_q, prev_d;
  logic [SLOT_W-1:0] nxt_q, nxt_d;
  logic [SLOT_W-1:0] new_q, new_d;

  logic [SLOT_W-1:0] free_slot;
  logic [SLOT_W-1:0] walk_addr;
  logic [CNT_W:0]    pos_x, cnt_x;
  logic              full, empty;
  logic [2:0]        dec_state, dec_op;
  logic [STAT_W-1:0] dec_status;
  logic [CNT_W-1:0]  dec_hops;

  // Lowest-numbered free slot.
  always_comb begin
    free_slot = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  // During a walk the address follows the link just read out of memory.
  assign walk_addr = rdv_q ? link_rdata_i : cur_q;

  assign pos_x = {1'b0, req_i.position};
  assign cnt_x = {1'b0, count_q};
  assign full  = cnt_x >= (CNT_W+1)'(DEPTH);
  assign empty = (count_q == '0);

  // Classify an incoming request against the current list length.
  always_comb begin
    dec_state  = S_DONE;
    dec_op     = OP_NONE;
    dec_status = ST_OK;
    dec_hops   = '0;
    case (req_i.req_type)
      REQ_PUSH_FRONT: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_op    = OP_INS_FRONT;
          dec_state = S_WR1;
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_op    = OP_INS_BACK;
          dec_state = S_WR1;
        end
      end
      REQ_INSERT_AT: begin
        if (full) begin
          dec_status = ST_FULL;
        end else if (pos_x == '0 || pos_x > cnt_x + (CNT_W+1)'(1)) begin
          dec_status = ST_RANGE;
        end else if (pos_x == (CNT_W+1)'(1)) begin
          dec_op    = OP_INS_FRONT;
          dec_state = S_WR1;
        end else if (pos_x == cnt_x + (CNT_W+1)'(1)) begin
          dec_op    = OP_INS_BACK;
          dec_state = S_WR1;
        end else begin
          dec_op    = OP_INS_MID;
          dec_state = S_WALK;
          dec_hops  = CNT_W'(pos_x - (CNT_W+1)'(2));
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_op    = OP_POP_FRONT;
          dec_state = S_CUR;
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else if (count_q == CNT_W'(1)) begin
          dec_op    = OP_POP_FRONT;
          dec_state = S_CUR;
        end else begin
          dec_op    = OP_DROP_AFTER;
          dec_state = S_WALK;
          dec_hops  = count_q - CNT_W'(2);
        end
      end
      REQ_REMOVE_AT: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else if (pos_x == '0 || pos_x > cnt_x) begin
          dec_status = ST_RANGE;
        end else if (pos_x == (CNT_W+1)'(1)) begin
          dec_op    = OP_POP_FRONT;
          dec_state = S_CUR;
        end else begin
          dec_op    = OP_DROP_AFTER;
          dec_state = S_WALK;
          dec_hops  = CNT_W'(pos_x - (CNT_W+1)'(2));
        end
      end
      default: begin
        dec_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    free_d    = free_q;
    hops_d    = hops_q;
    rdv_d     = rdv_q;
    val_d     = val_q;
    removed_d = removed_q;
    status_d  = status_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    nxt_d     = nxt_q;
    new_d     = new_q;

    mem_o.we_val  = 1'b0;
    mem_o.we_link = 1'b0;
    mem_o.waddr   = free_slot;
    mem_o.wval    = val_q;
    mem_o.wlink   = '0;
    mem_o.raddr   = cur_q;

    case (state_q)
      S_IDLE: begin
        // A pop at the front needs the head entry, so read it right away.
        mem_o.raddr = head_q;
        if (req_valid_i) begin
          val_d     = req_i.value;
          removed_d = '0;
          status_d  = dec_status;
          op_d      = dec_op;
          hops_d    = dec_hops;
          cur_d     = head_q;
          rdv_d     = 1'b0;
          state_d   = dec_state;
        end
      end
      S_WALK: begin
        mem_o.raddr = walk_addr;
        cur_d       = walk_addr;
        rdv_d       = 1'b1;
        if (hops_q == '0) begin
          prev_d  = walk_addr;
          state_d = S_NEXT;
        end else begin
          hops_d = hops_q - CNT_W'(1);
        end
      end
      S_NEXT: begin
        // Link read data is the successor of the predecessor slot.
        mem_o.raddr = link_rdata_i;
        if (op_q == OP_INS_MID) begin
          nxt_d   = link_rdata_i;
          state_d = S_WR1;
        end else begin
          cur_d   = link_rdata_i;
          state_d = S_CUR;
        end
      end
      S_CUR: begin
        removed_d     = val_rdata_i;
        free_d[cur_q] = 1'b1;
        count_d       = count_q - CNT_W'(1);
        if (op_q == OP_POP_FRONT) begin
          if (count_q == CNT_W'(1)) begin
            head_d = '0;
            tail_d = '0;
          end else begin
            head_d = link_rdata_i;
          end
        end else begin
          mem_o.we_link = 1'b1;
          mem_o.waddr   = prev_q;
          if (cur_q == tail_q) begin
            tail_d      = prev_q;
            mem_o.wlink = '0;
          end else begin
            mem_o.wlink = link_rdata_i;
          end
        end
        state_d = S_DONE;
      end
      S_WR1: begin
        mem_o.we_val      = 1'b1;
        mem_o.we_link     = 1'b1;
        mem_o.waddr       = free_slot;
        free_d[free_slot] = 1'b0;
        new_d             = free_slot;
        state_d           = S_WR2;
        if (op_q == OP_INS_FRONT) begin
          mem_o.wlink = empty ? '0 : head_q;
          head_d      = free_slot;
          if (empty) begin
            tail_d = free_slot;
          end
          count_d = count_q + CNT_W'(1);
          state_d = S_DONE;
        end else if (op_q == OP_INS_BACK) begin
          mem_o.wlink = '0;
          if (empty) begin
            head_d  = free_slot;
            tail_d  = free_slot;
            count_d = count_q + CNT_W'(1);
            state_d = S_DONE;
          end
        end else begin
          mem_o.wlink = nxt_q;
        end
      end
      S_WR2: begin
        // Second link write: hook the new slot behind its predecessor.
        mem_o.we_link = 1'b1;
        mem_o.wlink   = new_q;
        if (op_q == OP_INS_BACK) begin
          mem_o.waddr = tail_q;
          tail_d      = new_q;
        end else begin
          mem_o.waddr = prev_q;
        end
        count_d = count_q + CNT_W'(1);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_NONE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      free_q  <= '1;
      hops_q  <= '0;
      rdv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      free_q  <= free_d;
      hops_q  <= hops_d;
      rdv_q   <= rdv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    removed_q <= removed_d;
    status_q  <= status_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    nxt_q     <= nxt_d;
    new_q     <= new_d;
  end

  assign sts_o.busy      = (state_q != S_IDLE);
  assign sts_o.res_valid = (state_q == S_DONE);

  assign rsp_o.status        = status_q;
  assign rsp_o.removed_value = removed_q;
  assign rsp_o.count         = count_q;

endmodule

`default_nettype wire

// File: rtl/core/bounded_ordered_list_engine_top.sv
// Top level of the ordered list engine: memories, sequencer and result register.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+------------------
//   in      | input     | in_valid_i / in_stall_o  | bole_pkg::req_t
//   out     | output    | out_valid_o / out_stall_i | bole_pkg::rsp_t
//
// One item is worked on at a time. Push front writes in S_WR1, push back in
// S_WR1 and then S_WR2 on a non-empty list, pop front reads in S_CUR. Other
// removals and mid-list inserts walk the links one read per cycle.
// After reset the list is empty and every slot is free; no clearing pass runs.
// A waiting result sits in the output register while the next item is taken;
// the sequencer then holds its result until that register frees up.
`include "bounded_ordered_list_engine_top_defines.svh"
`default_nettype none

module bounded_ordered_list_engine_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire bole_pkg::req_t in_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output bole_pkg::rsp_t      out_o
);
  import bole_pkg::*;

  ctl_sts_t          sts;
  rsp_t              rsp;
  mem_req_t          mem;
  logic [VAL_W-1:0]  val_rdata;
  logic [SLOT_W-1:0] link_rdata;
  logic              res_ready;
  logic              out_valid_q;
  rsp_t              out_q;

  bole_ram #(
    .WIDTH (VAL_W),
    .WORDS (DEPTH)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (mem.we_val),
    .waddr_i (mem.waddr),
    .wdata_i (mem.wval),
    .raddr_i (mem.raddr),
    .rdata_o (val_rdata)
  );

  bole_ram #(
    .WIDTH (SLOT_W),
    .WORDS (DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem.we_link),
    .waddr_i (mem.waddr),
    .wdata_i (mem.wlink),
    .raddr_i (mem.raddr),
    .rdata_o (link_rdata)
  );

  bole_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (in_valid_i),
    .req_i        (in_i),
    .res_ready_i  (res_ready),
    .sts_o        (sts),
    .rsp_o        (rsp),
    .mem_o        (mem),
    .val_rdata_i  (val_rdata),
    .link_rdata_i (link_rdata)
  );

  assign in_stall_o = sts.busy;

  // The output register takes a new item when empty or being drained.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= sts.res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && sts.res_valid) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `BOLE_ASSERT(a_accept_starts_work, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> sts.busy)
  `BOLE_ASSERT(a_load_from_ctrl, clk_i, rst_ni, $rose(out_valid_q) |-> $past(sts.res_valid))
  `BOLE_ASSERT(a_removed_only_ok, clk_i, rst_ni, (out_valid_o && out_o.removed_value != '0) |-> (out_o.status == ST_OK))
  `BOLE_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, out_valid_o && (out_o.count > CNT_W'(DEPTH)))

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Testbench for the ordered list engine: request and response checks against a value-queue predictor.
`timescale 1ns / 100ps

module testbench;
  import bole_pkg::*;

  localparam int RANDOM_ITEMS  = 1780;
  localparam int MID_DRAIN_AT  = 900;
  localparam int HOLD_OFF_AT   = 700;
  localparam int HOLD_OFF_LEN  = 300;
  localparam int CALM_TAIL     = 150;
  localparam int SETTLE_CYCLES = 2 * (DEPTH + 3);
  localparam int STUCK_LIMIT   = 3000;
  localparam int PRINT_LIMIT   = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  req_t in_req = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  rsp_t out_o;

  bounded_ordered_list_engine_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_i        (in_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_o       (out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Values in list order, front first; slot placement is invisible at the ports.
  logic [VAL_W-1:0] list_values[$];
  rsp_t expected_rsps[$];
  req_t pending_reqs[$];
  bit   drain_flags[$];

  int   gen_count;
  int   mismatch_count;
  int   requests_sent;
  int   results_seen;
  int   cycle_count;
  int   deepest_list;
  int   status_seen[4];
  int   gap_left;
  int   stall_left;
  int   hold_cycles;
  int   quiet_left;
  int   stuck_cycles;
  logic item_taken = 1'b0;
  logic long_hold = 1'b0;
  logic hold_done = 1'b0;
  logic quiet = 1'b0;
  logic late_run = 1'b0;

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Applies one request to the list and returns the answer it should get.
  function automatic rsp_t list_apply(req_t r);
    rsp_t a;
    int   n;
    int   p;
    a = '0;
    a.status = ST_OK;
    n = list_values.size();
    p = int'(r.position);
    case (r.req_type)
      REQ_PUSH_FRONT: begin
        if (n >= DEPTH) a.status = ST_FULL;
        else list_values.push_front(r.value);
      end
      REQ_PUSH_BACK: begin
        if (n >= DEPTH) a.status = ST_FULL;
        else list_values.push_back(r.value);
      end
      REQ_INSERT_AT: begin
        if (n >= DEPTH) a.status = ST_FULL;
        else if (p < 1 || p > n + 1) a.status = ST_RANGE;
        else list_values.insert(p - 1, r.value);
      end
      REQ_POP_FRONT: begin
        if (n == 0) a.status = ST_EMPTY;
        else a.removed_value = list_values.pop_front();
      end
      REQ_POP_BACK: begin
        if (n == 0) a.status = ST_EMPTY;
        else a.removed_value = list_values.pop_back();
      end
      REQ_REMOVE_AT: begin
        if (n == 0) a.status = ST_EMPTY;
        else if (p < 1 || p > n) a.status = ST_RANGE;
        else begin
          a.removed_value = list_values[p - 1];
          list_values.delete(p - 1);
        end
      end
      default: ;
    endcase
    a.count = CNT_W'(list_values.size());
    return a;
  endfunction

  function automatic logic [VAL_W-1:0] rand_word();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return VAL_W'($urandom);
  endfunction

  // Mostly legal positions for the current length, some at the edges, some anywhere.
  function automatic logic [4:0] pick_position(logic [TYPE_W-1:0] kind);
    int roll;
    int top;
    roll = $urandom_range(0, 9);
    top = (kind == REQ_INSERT_AT) ? gen_count + 1 : gen_count;
    if (roll == 0) return 5'($urandom_range(0, 31));
    if (roll == 1) return 5'($urandom_range(0, 1) ? 0 : top + 1);
    if (top < 1) return 5'(1);
    return 5'($urandom_range(1, top));
  endfunction

  task automatic queue_req(logic [TYPE_W-1:0] kind, logic [VAL_W-1:0] v, logic [4:0] p,
                           bit drain);
    req_t r;
    int   pi;
    r.req_type = kind;
    r.value    = v;
    r.position = p;
    pi = int'(p);
    pending_reqs.push_back(r);
    drain_flags.push_back(drain);
    // The generator follows the length so that positions can be aimed.
    case (kind)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: if (gen_count < DEPTH) gen_count++;
      REQ_INSERT_AT: if (gen_count < DEPTH && pi >= 1 && pi <= gen_count + 1) gen_count++;
      REQ_POP_FRONT, REQ_POP_BACK: if (gen_count > 0) gen_count--;
      REQ_REMOVE_AT: if (gen_count > 0 && pi >= 1 && pi <= gen_count) gen_count--;
      default: ;
    endcase
  endtask

  // Request side: holds a stalled item, otherwise idles in bursts, waits out a drain or sends the next one.
  always @(negedge clk_i) begin : drive_requests
    logic next_valid;
    next_valid = 1'b0;
    if (!rst_ni) begin
      next_valid = 1'b0;
    end else if (in_valid && !item_taken) begin
      next_valid = 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (pending_reqs.size() == 0) begin
      next_valid = 1'b0;
    end else if (drain_flags[0] && expected_rsps.size() != 0) begin
      next_valid = 1'b0;
    end else if (!quiet && !late_run && $urandom_range(0, 9) == 0) begin
      gap_left = $urandom_range(0, 11);
    end else begin
      in_req <= pending_reqs.pop_front();
      void'(drain_flags.pop_front());
      requests_sent++;
      next_valid = 1'b1;
    end
    in_valid <= next_valid;
  end

  // Response side stall: random bursts, plus the long hold-off.
  always @(negedge clk_i) begin : drive_stall
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (long_hold) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && !late_run && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // One long hold-off on the response side so the engine backs up into its input.
  always @(posedge clk_i) begin : hold_off
    if (rst_ni) begin
      if (long_hold) begin
        if (hold_cycles == 0) long_hold <= 1'b0;
        else hold_cycles <= hold_cycles - 1;
      end else if (!hold_done && requests_sent >= HOLD_OFF_AT) begin
        long_hold   <= 1'b1;
        hold_cycles <= HOLD_OFF_LEN;
        hold_done   <= 1'b1;
      end
    end
  end

  // Alternates stretches with and without idling; the tail of the run has none.
  always @(posedge clk_i) begin : pace
    late_run <= pending_reqs.size() < CALM_TAIL;
    if (quiet_left == 0) begin
      quiet_left <= $urandom_range(30, 200);
      quiet      <= ($urandom_range(0, 2) == 0);
    end else begin
      quiet_left <= quiet_left - 1;
    end
  end

  always @(posedge clk_i) begin : monitor
    rsp_t want;
    rsp_t pred;
    if (rst_ni) begin
      cycle_count++;
      item_taken <= in_valid && !in_stall_o;
      if (in_valid && !in_stall_o) begin
        pred = list_apply(in_req);
        expected_rsps.push_back(pred);
        if (int'(pred.count) > deepest_list) deepest_list = int'(pred.count);
      end
      if (out_valid_o && !out_stall) begin
        results_seen++;
        if (expected_rsps.size() == 0) begin
          report_mismatch($sformatf("result with none outstanding (status %0d, count %0d)",
                                    out_o.status, out_o.count));
        end else begin
          want = expected_rsps.pop_front();
          status_seen[want.status]++;
          if (out_o.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      results_seen, out_o.status, want.status));
          if (out_o.removed_value !== want.removed_value)
            report_mismatch($sformatf("result %0d removed_value 0x%08h, expected 0x%08h",
                                      results_seen, out_o.removed_value, want.removed_value));
          if (out_o.count !== want.count)
            report_mismatch($sformatf("result %0d count %0d, expected %0d",
                                      results_seen, out_o.count, want.count));
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $time, STUCK_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int useful;
    int burst;
    int roll;
    int grow_pct;
    logic [TYPE_W-1:0] kind;

    // Directed: removals on an empty list, every insert path, every removal path.
    queue_req(REQ_POP_FRONT,  rand_word(), 5'd1, 1'b0);
    queue_req(REQ_POP_BACK,   rand_word(), 5'd0, 1'b0);
    queue_req(REQ_REMOVE_AT,  rand_word(), 5'd1, 1'b0);
    queue_req(REQ_INSERT_AT,  32'h1234_5678, 5'd0, 1'b0);
    queue_req(REQ_INSERT_AT,  32'h1234_5678, 5'd2, 1'b0);
    queue_req(REQ_INSERT_AT,  32'h0000_0000, 5'd1, 1'b0);
    queue_req(REQ_PUSH_BACK,  32'hFFFF_FFFF, 5'd31, 1'b0);
    queue_req(REQ_INSERT_AT,  32'hA5A5_A5A5, 5'd3, 1'b0);
    queue_req(REQ_INSERT_AT,  32'h5A5A_5A5A, 5'd2, 1'b0);
    queue_req(REQ_PUSH_FRONT, 32'h0000_0001, 5'd16, 1'b0);
    queue_req(REQ_INSERT_AT,  32'hDEAD_BEEF, 5'd31, 1'b0);
    queue_req(REQ_REMOVE_AT,  rand_word(), 5'd0, 1'b0);
    queue_req(REQ_REMOVE_AT,  rand_word(), 5'd6, 1'b0);
    queue_req(REQ_REMOVE_AT,  rand_word(), 5'd3, 1'b0);
    queue_req(REQ_REMOVE_AT,  rand_word(), 5'd4, 1'b0);
    queue_req(REQ_POP_BACK,   rand_word(), 5'd0, 1'b0);
    queue_req(REQ_POP_FRONT,  rand_word(), 5'd0, 1'b0);
    queue_req(REQ_POP_BACK,   rand_word(), 5'd0, 1'b0);
    queue_req(TYPE_W'(6),     32'hFFFF_FFFF, 5'd31, 1'b0);
    queue_req(TYPE_W'(7),     32'hFFFF_FFFF, 5'd31, 1'b0);

    // Fill to capacity after a full drain, then try every insert on a full list and removals at and past its end.
    for (int i = 0; i < DEPTH; i++)
      queue_req(REQ_PUSH_BACK, rand_word(), 5'($urandom_range(0, 31)), i == 0);
    queue_req(REQ_PUSH_FRONT, rand_word(), 5'd0, 1'b0);
    queue_req(REQ_PUSH_BACK,  rand_word(), 5'd0, 1'b0);
    queue_req(REQ_INSERT_AT,  rand_word(), 5'd1, 1'b0);
    queue_req(REQ_INSERT_AT,  rand_word(), 5'd0, 1'b0);
    queue_req(REQ_REMOVE_AT,  rand_word(), 5'd17, 1'b0);
    queue_req(REQ_REMOVE_AT,  rand_word(), 5'd16, 1'b0);

    // Random bursts that lean toward growing, shrinking or neither.
    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: grow_pct = 75;
        1: grow_pct = 25;
        default: grow_pct = 50;
      endcase
      burst = $urandom_range(8, 40);
      repeat (burst) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) kind = TYPE_W'($urandom_range(6, 7));
        else if (roll < 3 + grow_pct) kind = TYPE_W'($urandom_range(0, 2));
        else kind = TYPE_W'($urandom_range(3, 5));
        if (kind == REQ_INSERT_AT || kind == REQ_REMOVE_AT)
          queue_req(kind, rand_word(), pick_position(kind), useful == MID_DRAIN_AT);
        else
          queue_req(kind, rand_word(), 5'($urandom_range(0, 31)), useful == MID_DRAIN_AT);
        if (kind <= REQ_REMOVE_AT) useful++;
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests in %0d cycles, %0d results checked, list reached %0d entries.",
             requests_sent, cycle_count, results_seen, deepest_list);
    $display("Answers seen: %0d ok, %0d full, %0d empty, %0d out of range; %0d mismatches.",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_RANGE], mismatch_count);
    if (mismatch_count == 0 && expected_rsps.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/bole_pkg.sv
rtl/core/bole_ram.sv
rtl/core/bole_ctrl.sv
rtl/core/bounded_ordered_list_engine_top.sv
tb/testbench.sv
